/* design/dct_pkg.sv */
// ============================================================================
// dct_pkg
// Shared constants and constant tables of the decaying chirp tone generator.
// ============================================================================
`default_nettype none

package dct_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int EXP_TABLE_BITS  = 8;

    localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
    localparam int EXP_LEN     = 1 << EXP_TABLE_BITS;
    // Address into the quarter table, wide enough to reach QUARTER_LEN itself.
    localparam int SINE_ADDR_W = SINE_TABLE_BITS - 1;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // Pipeline depth from accept to result register.
    localparam int NSTAGE = 6;

    localparam int MAG_W   = 15;   // quarter-wave magnitude, Q1.15 without sign
    localparam int ENV_W   = 31;   // envelope, Q2.30, never above one
    localparam int ENVPK_W = ENV_W + MAG_W;
    localparam int ENVPK_LO_W = ENVPK_W / 2;
    localparam int PART_W  = MAG_W + ENVPK_W - ENVPK_LO_W;
    localparam int PROD_W  = MAG_W + ENVPK_W;

    typedef logic [MAG_W-1:0] sine_tab_t [0:QUARTER_LEN];
    typedef logic [ENV_W-1:0] exp_tab_t  [0:EXP_LEN-1];

    // Restoring long division, used only while the constant tables are built.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Taylor series of sin on a Q30 argument, rounded to Q1.15.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned q;
        longint unsigned den;
        x    = (longint'(k) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            den  = longint'((2 * n) * (2 * n + 1));
            term = udiv64((term * x2) >> 30, den);
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (longint'(sum) + (64'd1 << 14)) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[MAG_W-1:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            tab[k] = quarter_sine(k);
        end
        return tab;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v    = v_in;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Entry k holds 2^-(k / EXP_LEN) in Q2.30, built from repeated square roots.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t        tab;
        longint unsigned root [0:EXP_TABLE_BITS];
        longint unsigned v;
        root[0] = ONE_Q30 >> 1;
        for (int m = 1; m <= EXP_TABLE_BITS; m++) begin
            root[m] = isqrt64(root[m-1] << 30);
        end
        for (int k = 0; k < EXP_LEN; k++) begin
            v = ONE_Q30;
            for (int p = 0; p < EXP_TABLE_BITS; p++) begin
                if (((k >> p) & 1) == 1) begin
                    v = (v * root[EXP_TABLE_BITS - p]) >> 30;
                end
            end
            tab[k] = v[ENV_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();
    localparam exp_tab_t  EXP_TAB  = build_exp_tab();

endpackage

`default_nettype wire

/* design/dct_phase.sv */
// ============================================================================
// dct_phase
// Three-stage chirp phase path: start_step*i + sweep_coef*i*i modulo one.
// ============================================================================
`default_nettype none

module dct_phase
    import dct_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic [2:0]                 stage_en,
    input  wire logic [15:0]                sample_index,
    input  wire logic [31:0]                start_step,
    input  wire logic signed [39:0]         sweep_coef,
    output logic      [SINE_TABLE_BITS-1:0] phase_idx
);

    logic [47:0] lin_full;
    logic [31:0] sq_next;
    logic [31:0] sq_reg;
    logic [31:0] lin_reg;

    logic [47:0] sw48;
    logic [55:0] plo_full;
    logic [55:0] phi_full;
    logic [47:0] plo_reg;
    logic [23:0] phi_reg;
    logic [31:0] lin2_reg;

    logic [47:0]                phase_sum;
    logic [SINE_TABLE_BITS-1:0] idx_reg;

    // Only the low 32 bits of the linear term survive the shift into a 48-bit phase.
    assign lin_full = 48'(start_step) * 48'(sample_index);
    assign sq_next  = 32'(sample_index) * 32'(sample_index);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sq_reg  <= sq_next;
            lin_reg <= lin_full[31:0];
        end
    end

    // The 40x32 product is split at bit 24; of the upper part only 24 bits stay below 2^48.
    assign sw48     = {{8{sweep_coef[39]}}, sweep_coef};
    assign plo_full = 56'(sw48[23:0]) * 56'(sq_reg);
    assign phi_full = 56'(sw48[47:24]) * 56'(sq_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            plo_reg  <= plo_full[47:0];
            phi_reg  <= phi_full[23:0];
            lin2_reg <= lin_reg;
        end
    end

    assign phase_sum = {lin2_reg, 16'b0} + plo_reg + {phi_reg, 24'b0};

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            idx_reg <= phase_sum[47 -: SINE_TABLE_BITS];
        end
    end

    assign phase_idx = idx_reg;

endmodule

`default_nettype wire

/* design/dct_env.sv */
// ============================================================================
// dct_env
// Three-stage envelope path: 2^-(decay_rate*i) scaled by the peak level.
// ============================================================================
`default_nettype none

module dct_env
    import dct_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [2:0]         stage_en,
    input  wire logic [15:0]        sample_index,
    input  wire logic [23:0]        decay_rate,
    input  wire logic [14:0]        peak_level,
    output logic      [ENVPK_W-1:0] env_level
);

    logic [39:0] dprod_reg;

    logic [15:0]               shift;
    logic [EXP_TABLE_BITS-1:0] frac_idx;
    logic [ENV_W-1:0]          frac_val;
    logic [ENV_W-1:0]          env_next;
    logic [ENV_W-1:0]          env_reg;

    logic [ENVPK_W-1:0] envpk_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dprod_reg <= 40'(decay_rate) * 40'(sample_index);
        end
    end

    // Integer part of the exponent is a right shift, the fraction a table lookup.
    assign shift    = dprod_reg[39:24];
    assign frac_idx = dprod_reg[23 -: EXP_TABLE_BITS];
    assign frac_val = EXP_TAB[frac_idx];

    always_comb begin
        if (shift >= 16'd31) begin
            env_next = '0;
        end else begin
            env_next = frac_val >> shift[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            env_reg <= env_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            envpk_reg <= ENVPK_W'(env_reg) * ENVPK_W'(peak_level);
        end
    end

    assign env_level = envpk_reg;

endmodule

`default_nettype wire

/* design/dct_scale.sv */
// ============================================================================
// dct_scale
// Quarter-wave sine lookup, split amplitude multiply, truncation and clamp.
// ============================================================================
`default_nettype none

module dct_scale
    import dct_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic [2:0]                 stage_en,
    input  wire logic [SINE_TABLE_BITS-1:0] phase_idx,
    input  wire logic [ENVPK_W-1:0]         env_level,
    input  wire logic                       in_range,
    output logic      [15:0]                sample
);

    logic [1:0]                 quad;
    logic [SINE_ADDR_W-1:0]     k_addr;
    logic [SINE_ADDR_W-1:0]     tab_addr;
    logic [MAG_W-1:0]           mag_reg;
    logic                       neg4_reg;
    logic [ENVPK_W-1:0]         envpk4_reg;

    logic [PART_W-1:0]          plo_reg;
    logic [PART_W-1:0]          phi_reg;
    logic                       neg5_reg;

    logic [PROD_W:0]            prod;
    logic [15:0]                prod_top;
    logic [MAG_W-1:0]           mag_out;
    logic [15:0]                sample_next;
    logic [15:0]                sample_reg;

    assign quad   = phase_idx[SINE_TABLE_BITS-1 -: 2];
    assign k_addr = {1'b0, phase_idx[SINE_TABLE_BITS-3:0]};

    // Quadrants one and three run the table backward.
    always_comb begin
        if (quad[0]) begin
            tab_addr = SINE_ADDR_W'(QUARTER_LEN) - k_addr;
        end else begin
            tab_addr = k_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mag_reg    <= SINE_TAB[tab_addr];
            neg4_reg   <= quad[1];
            envpk4_reg <= env_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            plo_reg  <= PART_W'(mag_reg) * PART_W'(envpk4_reg[ENVPK_LO_W-1:0]);
            phi_reg  <= PART_W'(mag_reg) * PART_W'(envpk4_reg[ENVPK_W-1:ENVPK_LO_W]);
            neg5_reg <= neg4_reg;
        end
    end

    assign prod     = {phi_reg, {ENVPK_LO_W{1'b0}}} + (PROD_W + 1)'(plo_reg);
    assign prod_top = 16'(prod >> 45);

    always_comb begin
        if (prod_top > 16'd32767) begin
            mag_out = '1;
        end else begin
            mag_out = prod_top[MAG_W-1:0];
        end
        if (!in_range) begin
            sample_next = '0;
        end else if (neg5_reg) begin
            sample_next = 16'd0 - {1'b0, mag_out};
        end else begin
            sample_next = {1'b0, mag_out};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

/* design/decaying_chirp_tone_generator.sv */
// ============================================================================
// decaying_chirp_tone_generator
// Linear chirp oscillator with an exponential decay envelope.
// ============================================================================
// Usage: each item on the s_ channel carries a sample index; the m_ channel
// returns one item per input item, in order, with the signed 16-bit sample
// in m_tdata and m_tlast set when the index equals frame_count - 1. Indices
// at or past frame_count give a zero sample.
// The datapath is a six-stage pipeline: phase and envelope products, then the
// phase sum and level scaling, the sine table read, a split 15x46 multiply,
// and the truncate/clamp stage that feeds the output register. One item is
// taken per cycle unless m_tready stalls. Each stage advances when it is
// empty or its successor advances, so a stall on m_tready fills bubbles and
// only then drops s_tready; no item is lost or repeated. Configuration is
// written over APB at byte address 8*index, by the user only while no item
// is in flight; the block does not enforce this. Reads return the register.
// Reset empties the pipeline and loads the default tone settings.
// ============================================================================
`default_nettype none

module decaying_chirp_tone_generator
    import dct_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] sample_index

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,    // [15:0] sample
    output logic             m_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        REG_FRAME_COUNT = 3'd0,
        REG_START_STEP  = 3'd1,
        REG_SWEEP_COEF  = 3'd2,
        REG_DECAY_RATE  = 3'd3,
        REG_PEAK_LEVEL  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic in_range;
        logic last;
    } flags_t;

    logic [15:0]        frame_count_reg;
    logic [31:0]        start_step_reg;
    logic signed [39:0] sweep_coef_reg;
    logic [23:0]        decay_rate_reg;
    logic [14:0]        peak_level_reg;

    logic [2:0]  reg_idx;
    logic        cfg_write;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] stage_en;
    flags_t            flags_reg [0:NSTAGE-1];
    flags_t            flags_next;

    logic [SINE_TABLE_BITS-1:0] phase_idx;
    logic [ENVPK_W-1:0]         env_level;
    logic [15:0]                sample;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= 16'd2205;
            start_step_reg  <= 32'd175304788;
            sweep_coef_reg  <= 40'sd2315700000;
            decay_rate_reg  <= 24'd13175;
            peak_level_reg  <= 15'd18000;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_FRAME_COUNT: frame_count_reg <= pwdata[15:0];
                REG_START_STEP:  start_step_reg  <= pwdata[31:0];
                REG_SWEEP_COEF:  sweep_coef_reg  <= pwdata[39:0];
                REG_DECAY_RATE:  decay_rate_reg  <= pwdata[23:0];
                REG_PEAK_LEVEL:  peak_level_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_COUNT: prdata = 64'(frame_count_reg);
            REG_START_STEP:  prdata = 64'(start_step_reg);
            REG_SWEEP_COEF:  prdata = {24'b0, sweep_coef_reg};
            REG_DECAY_RATE:  prdata = 64'(decay_rate_reg);
            REG_PEAK_LEVEL:  prdata = 64'(peak_level_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or drains onward.
    // ------------------------------------------------------------------
    always_comb begin
        stage_en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int s = NSTAGE - 2; s >= 0; s--) begin
            stage_en[s] = !valid_reg[s] || stage_en[s+1];
        end
    end

    assign s_tready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int s = 1; s < NSTAGE; s++) begin
                if (stage_en[s]) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    assign flags_next.in_range = s_tdata < frame_count_reg;
    assign flags_next.last     = (17'(s_tdata) + 17'd1) == 17'(frame_count_reg);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            flags_reg[0] <= flags_next;
        end
        for (int s = 1; s < NSTAGE; s++) begin
            if (stage_en[s]) begin
                flags_reg[s] <= flags_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    dct_phase u_phase (
        .aclk         (aclk),
        .stage_en     (stage_en[2:0]),
        .sample_index (s_tdata),
        .start_step   (start_step_reg),
        .sweep_coef   (sweep_coef_reg),
        .phase_idx    (phase_idx)
    );

    dct_env u_env (
        .aclk         (aclk),
        .stage_en     (stage_en[2:0]),
        .sample_index (s_tdata),
        .decay_rate   (decay_rate_reg),
        .peak_level   (peak_level_reg),
        .env_level    (env_level)
    );

    dct_scale u_scale (
        .aclk      (aclk),
        .stage_en  (stage_en[5:3]),
        .phase_idx (phase_idx),
        .env_level (env_level),
        .in_range  (flags_reg[4].in_range),
        .sample    (sample)
    );

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = sample;
    assign m_tlast  = flags_reg[NSTAGE-1].last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    a_zero_past_end : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !flags_reg[NSTAGE-1].in_range |-> m_tdata == 16'd0)
        else $error("nonzero sample for an index past the frame");

    a_last_in_frame : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> flags_reg[NSTAGE-1].in_range)
        else $error("last flag on an index outside the frame");

    a_clamped : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'h8000)
        else $error("sample outside the clamp range");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ============================================================================
// testbench
// Self-checking bench for the decaying chirp tone generator.
// Sample indices go in on the s_ stream and every result item on the m_ stream
// is compared with a local model of the tone: the phase sum, the quarter-wave
// sine lookup, the power-of-two decay and the scaling and clamp. Register
// settings are changed over APB between phases, including extreme and
// out-of-range values. Directed corners come first, then random sounds with
// bursty input, random output stalls and one long output hold-off.
// ============================================================================

module testbench;

    import dct_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 2;
    localparam int          RANDOM_ITEMS  = 1050;
    localparam int          RANDOM_PHASES = 8;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          REPORT_LIMIT  = 200;
    localparam longint      CYCLE_LIMIT   = 400000;

    typedef enum int {
        REG_FRAME_COUNT = 0,
        REG_START_STEP  = 1,
        REG_SWEEP_COEF  = 2,
        REG_DECAY_RATE  = 3,
        REG_PEAK_LEVEL  = 4,
        REG_SPARE       = 5
    } cfg_reg_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PATTERN
    } ready_mode_t;

    typedef struct {
        bit   [15:0] index;
        logic [15:0] sample;
        logic        last;
    } tone_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [15:0] sample_index
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] sample
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    decaying_chirp_tone_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Local copy of the tone settings and of the two lookup tables.
    bit [15:0] tone_frame_count;
    bit [31:0] tone_start_step;
    bit [39:0] tone_sweep_coef;
    bit [23:0] tone_decay_rate;
    bit [14:0] tone_peak_level;

    bit [14:0] quarter_wave [0:QUARTER_LEN];
    bit [30:0] pow2_frac    [0:EXP_LEN-1];

    tone_result_t expected_samples [$];
    tone_result_t oldest_tone;

    int     mismatch_count;
    int     items_sent;
    int     results_checked;
    int     settings_count;
    int     input_stall_cycles;
    longint cycle_count;

    bit paced;
    int burst_left;

    int          hold_request;
    int          hold_left;
    ready_mode_t ready_mode;
    int          mode_left;
    bit [7:0]    ready_pattern;

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit, %0d results outstanding",
                     $time, expected_samples.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tone model
    // ------------------------------------------------------------------------

    // Quarter-wave sine entry from an eleven-term Taylor series on a Q30 angle.
    function automatic bit [14:0] taylor_quarter(int unsigned k);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] term;
        bit [63:0] rounded;
        longint    acc;
        x    = (64'(k) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        rounded = (64'(acc) + 64'd16384) >> 15;
        return (rounded > 64'd32767) ? 15'h7FFF : rounded[14:0];
    endfunction

    function automatic bit [63:0] root_floor(bit [63:0] v);
        bit [63:0] rem;
        bit [63:0] res;
        bit [63:0] probe;
        rem   = v;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > rem) begin
            probe = probe >> 2;
        end
        while (probe != 0) begin
            if (rem >= res + probe) begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // halvings[m] holds 2^-(2^-m) in Q2.30; each table entry multiplies the
    // ones selected by the bits of its index.
    function automatic void build_lookup_tables();
        bit [63:0] halvings [0:EXP_TABLE_BITS];
        bit [63:0] acc;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            quarter_wave[k] = taylor_quarter(k);
        end
        halvings[0] = 64'd1 << 29;
        for (int m = 1; m <= EXP_TABLE_BITS; m++) begin
            halvings[m] = root_floor(halvings[m-1] << 30);
        end
        for (int k = 0; k < EXP_LEN; k++) begin
            acc = 64'd1 << 30;
            for (int p = 0; p < EXP_TABLE_BITS; p++) begin
                if (((k >> p) & 1) == 1) begin
                    acc = (acc * halvings[EXP_TABLE_BITS - p]) >> 30;
                end
            end
            pow2_frac[k] = acc[30:0];
        end
    endfunction

    function automatic tone_result_t predict_tone(bit [15:0] idx);
        tone_result_t                 r;
        bit [63:0]                    i64;
        bit [63:0]                    sweep64;
        bit [63:0]                    phase;
        bit [63:0]                    mag;
        bit [63:0]                    dprod;
        bit [63:0]                    shift;
        bit [63:0]                    env;
        bit [63:0]                    prod;
        bit [SINE_TABLE_BITS-1:0]     slot;
        bit [1:0]                     quadrant;
        bit [SINE_TABLE_BITS-3:0]     offset;
        i64      = 64'(idx);
        r.index  = idx;
        r.last   = (i64 + 64'd1 == 64'(tone_frame_count));
        r.sample = '0;
        if (i64 < 64'(tone_frame_count)) begin
            sweep64  = {{24{tone_sweep_coef[39]}}, tone_sweep_coef};
            phase    = ((64'(tone_start_step) * i64) << 16) + sweep64 * (i64 * i64);
            slot     = phase[47 -: SINE_TABLE_BITS];
            quadrant = slot[SINE_TABLE_BITS-1 -: 2];
            offset   = slot[SINE_TABLE_BITS-3:0];
            mag      = quadrant[0] ? 64'(quarter_wave[QUARTER_LEN - offset])
                                   : 64'(quarter_wave[offset]);
            dprod    = 64'(tone_decay_rate) * i64;
            shift    = dprod >> 24;
            env      = 64'(pow2_frac[dprod[23 -: EXP_TABLE_BITS]]);
            env      = (shift >= 64'd31) ? 64'd0 : (env >> shift);
            prod     = (mag * 64'(tone_peak_level) * env) >> 45;
            if (prod > 64'd32767) begin
                prod = 64'd32767;
            end
            r.sample = quadrant[1] ? 16'(64'd0 - prod) : prod[15:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, longint want, longint got, bit [15:0] idx);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: index %0d: %s expected %0d, got %0d", $time, idx, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_tvalid && !s_tready) begin
                input_stall_cycles++;
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                results_checked++;
                if (expected_samples.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result item with no request pending: sample %0d, last %b",
                             $time, $signed(m_tdata), m_tlast);
                end else begin
                    oldest_tone = expected_samples.pop_front();
                    if (m_tdata !== oldest_tone.sample) begin
                        report_mismatch("sample", longint'($signed(oldest_tone.sample)),
                                        longint'($signed(m_tdata)), oldest_tone.index);
                    end
                    if (m_tlast !== oldest_tone.last) begin
                        report_mismatch("last_sample", longint'(oldest_tone.last),
                                        longint'(m_tlast), oldest_tone.index);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure: random modes, plus a long hold-off on request.
    // ------------------------------------------------------------------------

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode    = ready_mode_t'($urandom_range(READY_ALWAYS, READY_PATTERN));
                mode_left     = $urandom_range(20, 200);
                ready_pattern = 8'($urandom);
            end
            mode_left--;
            case (ready_mode)
                READY_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                READY_MOSTLY: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                READY_RARELY: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready      <= ready_pattern[0];
                    ready_pattern  = {ready_pattern[0], ready_pattern[7:1]};
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one sample index; while paced, items go out in bursts with gaps.
    task automatic send_index(bit [15:0] idx);
        int gap;
        if (paced) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
            burst_left--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= idx;
        do @(posedge aclk); while (!s_tready);
        expected_samples.push_back(predict_tone(idx));
        items_sent++;
    endtask

    // Lets every pending result come out and the pipeline go quiet.
    task automatic settle_pipeline();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_samples.size() != 0) begin
            mismatch_count += expected_samples.size();
            $display("%0t: %0d results never arrived", $time, expected_samples.size());
            expected_samples.delete();
        end
        repeat (NSTAGE + 4) @(posedge aclk);
    endtask

    task automatic apb_transfer(input bit is_write, input cfg_reg_t r,
                                input bit [63:0] wdata, output logic [63:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= 6'(int'(r) * 8);
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic bit [63:0] reg_mask(cfg_reg_t r);
        case (r)
            REG_FRAME_COUNT: return 64'hFFFF;
            REG_START_STEP:  return 64'hFFFF_FFFF;
            REG_SWEEP_COEF:  return 64'hFF_FFFF_FFFF;
            REG_DECAY_RATE:  return 64'hFF_FFFF;
            REG_PEAK_LEVEL:  return 64'h7FFF;
            default:         return 64'h0;
        endcase
    endfunction

    function automatic bit [63:0] tone_setting(cfg_reg_t r);
        case (r)
            REG_FRAME_COUNT: return 64'(tone_frame_count);
            REG_START_STEP:  return 64'(tone_start_step);
            REG_SWEEP_COEF:  return 64'(tone_sweep_coef);
            REG_DECAY_RATE:  return 64'(tone_decay_rate);
            REG_PEAK_LEVEL:  return 64'(tone_peak_level);
            default:         return 64'h0;
        endcase
    endfunction

    // Reads a register back; only the bits of its width are compared.
    task automatic check_reg(cfg_reg_t r);
        logic [63:0] got;
        bit   [63:0] mask;
        mask = reg_mask(r);
        apb_transfer(1'b0, r, 64'd0, got);
        if ((got & mask) !== (tone_setting(r) & mask)) begin
            mismatch_count++;
            $display("%0t: register %s read back: expected %h, got %h",
                     $time, r.name(), tone_setting(r) & mask, got & mask);
        end
    endtask

    task automatic write_reg(cfg_reg_t r, bit [63:0] value);
        logic [63:0] unused_rdata;
        apb_transfer(1'b1, r, value, unused_rdata);
        case (r)
            REG_FRAME_COUNT: tone_frame_count = value[15:0];
            REG_START_STEP:  tone_start_step  = value[31:0];
            REG_SWEEP_COEF:  tone_sweep_coef  = value[39:0];
            REG_DECAY_RATE:  tone_decay_rate  = value[23:0];
            REG_PEAK_LEVEL:  tone_peak_level  = value[14:0];
            default: ;
        endcase
        if (r != REG_SPARE) begin
            check_reg(r);
        end
    endtask

    task automatic set_tone(bit [63:0] frames, bit [63:0] start, bit [63:0] sweep,
                            bit [63:0] decay, bit [63:0] peak);
        settle_pipeline();
        write_reg(REG_FRAME_COUNT, frames);
        write_reg(REG_START_STEP, start);
        write_reg(REG_SWEEP_COEF, sweep);
        write_reg(REG_DECAY_RATE, decay);
        write_reg(REG_PEAK_LEVEL, peak);
        settings_count++;
    endtask

    // Sometimes sets bits above the register width, which must be dropped.
    function automatic bit [63:0] with_junk(bit [63:0] value, cfg_reg_t r);
        if ($urandom_range(0, 3) == 0) begin
            return value | ({$urandom, $urandom} & ~reg_mask(r));
        end
        return value;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_reset_tone();
        for (int r = REG_FRAME_COUNT; r <= REG_PEAK_LEVEL; r++) begin
            check_reg(cfg_reg_t'(r));
        end
        send_index(16'd0);
        send_index(16'd2204);
        send_index(16'd2205);
    endtask

    task automatic test_quadrant_boundaries();
        // Half a cycle per sample: the phase alternates between 0 and one half.
        set_tone(64'd65535, 64'h8000_0000, 64'd0, 64'd0, 64'd32767);
        send_index(16'd0);
        send_index(16'd1);
        // One table slot per sample, so the index walks through the quadrants.
        settle_pipeline();
        write_reg(REG_START_STEP, 64'd1 << (32 - SINE_TABLE_BITS));
        send_index(16'd256);
        send_index(16'd511);
        send_index(16'd512);
        send_index(16'd768);
        send_index(16'd1023);
    endtask

    task automatic test_envelope_cutoff();
        // The fastest decay shifts by just under one per sample; the envelope dies once
        // the shift reaches 31.
        settle_pipeline();
        write_reg(REG_DECAY_RATE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_index(16'd1);
        send_index(16'd31);
        send_index(16'd32);
    endtask

    task automatic test_sweep_extremes();
        set_tone(64'd65535, 64'd0, 64'hFFFF_FF80_0000_0000, 64'd0, 64'd32767);
        send_index(16'd1);
        send_index(16'd3);
        settle_pipeline();
        write_reg(REG_SWEEP_COEF, 64'h7F_FFFF_FFFF);
        send_index(16'd2);
        send_index(16'd65534);
    endtask

    task automatic test_unmapped_register();
        settle_pipeline();
        write_reg(REG_SPARE, {$urandom, $urandom});
        for (int r = REG_FRAME_COUNT; r <= REG_PEAK_LEVEL; r++) begin
            check_reg(cfg_reg_t'(r));
        end
        send_index(16'd4);
    endtask

    task automatic test_frame_edges();
        set_tone(64'd65535, 64'd175304788, 64'd2315700000, 64'd13175, 64'd18000);
        send_index(16'd65534);
        send_index(16'd65535);
        // A zero frame count silences every index and never marks a last one.
        settle_pipeline();
        write_reg(REG_FRAME_COUNT, 64'h1_0000);
        send_index(16'd0);
        send_index(16'd65535);
        settle_pipeline();
        write_reg(REG_FRAME_COUNT, 64'd1);
        send_index(16'd0);
        send_index(16'd1);
    endtask

    task automatic randomize_tone();
        bit [63:0] frames;
        bit [63:0] start;
        bit [63:0] sweep;
        bit [63:0] decay;
        bit [63:0] peak;
        case ($urandom_range(0, 4))
            0: frames = $urandom_range(1, 8);
            1: frames = $urandom_range(16, 300);
            2: frames = 64'd65535;
            3: frames = $urandom_range(1, 65535);
            default: frames = $urandom_range(1500, 3000);
        endcase
        case ($urandom_range(0, 3))
            0: start = ($urandom_range(0, 1) == 0) ? 64'd0 : 64'h8000_0000;
            1: start = 64'($urandom);
            default: start = $urandom_range(19000000, 780000000);
        endcase
        case ($urandom_range(0, 3))
            0: sweep = ($urandom_range(0, 1) == 0) ? 64'h80_0000_0000 : 64'h7F_FFFF_FFFF;
            1: sweep = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
            default: sweep = 64'(longint'($signed($urandom)));
        endcase
        case ($urandom_range(0, 4))
            0: decay = 64'd0;
            1: decay = 64'hFF_FFFF;
            2: decay = 64'($urandom) & 64'hFF_FFFF;
            default: decay = $urandom_range(0, 200000);
        endcase
        case ($urandom_range(0, 3))
            0: peak = 64'd0;
            1: peak = 64'd32767;
            default: peak = $urandom_range(0, 32767);
        endcase
        set_tone(with_junk(frames, REG_FRAME_COUNT), with_junk(start, REG_START_STEP),
                 with_junk(sweep, REG_SWEEP_COEF), with_junk(decay, REG_DECAY_RATE),
                 with_junk(peak, REG_PEAK_LEVEL));
    endtask

    // Most items are runs of consecutive indices, as when a sound is played;
    // the rest sit near the end of the frame or anywhere in the index range.
    task automatic test_random_tones();
        int        budget;
        int        sent;
        int        run_len;
        bit [15:0] run_start;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            randomize_tone();
            budget = RANDOM_ITEMS / RANDOM_PHASES;
            sent   = 0;
            while (sent < budget) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        run_start = ($urandom_range(0, 1) == 0 || tone_frame_count == 0)
                                    ? 16'd0 : 16'($urandom_range(0, tone_frame_count - 1));
                        run_len   = $urandom_range(4, 40);
                        for (int j = 0; j < run_len && sent < budget; j++) begin
                            send_index(16'(run_start + j));
                            sent++;
                        end
                    end
                    6, 7: begin
                        send_index(16'(int'(tone_frame_count) + $urandom_range(0, 4) - 3));
                        sent++;
                    end
                    default: begin
                        send_index(16'($urandom));
                        sent++;
                    end
                endcase
            end
        end
    endtask

    // The output is held off long enough for the pipeline to fill up and
    // push back on the input while items keep coming.
    task automatic test_output_backpressure();
        set_tone(64'd2205, 64'd175304788, 64'd2315700000, 64'd13175, 64'd18000);
        paced        = 1'b0;
        hold_request = 150;
        for (int j = 0; j < 48; j++) begin
            send_index(16'(j + 2180));
        end
        paced = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        paced        = 1'b1;
        burst_left   = 0;
        hold_request = 0;
        hold_left    = 0;
        mode_left    = 0;
        tone_frame_count = 16'd2205;
        tone_start_step  = 32'd175304788;
        tone_sweep_coef  = 40'd2315700000;
        tone_decay_rate  = 24'd13175;
        tone_peak_level  = 15'd18000;
        build_lookup_tables();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_tone();
        test_quadrant_boundaries();
        test_envelope_cutoff();
        test_sweep_extremes();
        test_unmapped_register();
        test_frame_edges();
        test_random_tones();
        test_output_backpressure();
        settle_pipeline();

        $display("Sent %0d sample indices under %0d tone settings; %0d results checked.",
                 items_sent, settings_count, results_checked);
        $display("Input was held back for %0d cycles; %0d mismatches found.",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
design/dct_pkg.sv
design/dct_phase.sv
design/dct_env.sv
design/dct_scale.sv
design/decaying_chirp_tone_generator.sv
dv/testbench.sv
